// ===== hw/rtl/dvre_pkg.sv =====
// shared types and constants for the distance vector relax engine
`timescale 1ns / 1ps

package dvre_pkg;

  localparam int OP_W          = 2;
  localparam int NBR_FIELD_W   = 2;
  localparam int DEST_FIELD_W  = 4;
  localparam int EST_FIELD_W   = 16;
  localparam int HOP_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int DEST_CNT_W    = 5;
  localparam int NBR_CNT_W     = 3;
  localparam int REPORT_W      = 3;
  localparam int NUM_COST_REGS = 4;
  localparam int COST_W        = 16;

  localparam logic [HOP_W-1:0]    NO_HOP       = 3'd4;
  localparam logic [REPORT_W-1:0] REPORT_FULL  = 3'd7;
  localparam logic [COST_W-1:0]   DEFAULT_COST = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NBR_IN_USE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_COST_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_COST_3 = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_NBR       = 2'd0,
    OP_LOAD_OWN       = 2'd1,
    OP_NBR_UNCHANGED  = 2'd2,
    OP_RELAX          = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_RELAX,
    ST_TAIL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [NBR_FIELD_W-1:0]  neighbor_index;
    logic [DEST_FIELD_W-1:0] destination;
    logic [EST_FIELD_W-1:0]  estimate;
  } in_word_t;

  typedef struct packed {
    logic [DEST_FIELD_W-1:0] dest_index;
    logic [EST_FIELD_W-1:0]  best_estimate;
    logic [HOP_W-1:0]        next_hop;
    logic                    entry_changed;
    logic                    table_changed;
    logic                    converged;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic [NUM_COST_REGS-1:0][COST_W-1:0] cost;
  } cost_set_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } relax_ctl_t;

endpackage

// ===== hw/rtl/dvre_cfg.sv =====
// configuration registers with clamped neighbour and destination counts
`timescale 1ns / 1ps

module dvre_cfg #(
  parameter int MAX_DESTINATIONS = 16,
  parameter int MAX_NEIGHBORS    = 4,
  parameter int DW               = 4,
  parameter int JW               = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dvre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dvre_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [DW-1:0]                     nd_m1,
  output logic [JW-1:0]                     nn_m1,
  output logic [dvre_pkg::REPORT_W:0]       nn_cnt,
  output dvre_pkg::cost_set_t               costs
);
  import dvre_pkg::*;

  logic [DEST_CNT_W-1:0] dest_cnt_r;
  logic [NBR_CNT_W-1:0]  nbr_cnt_r;
  cost_set_t             costs_r;
  int unsigned           nd_v;
  int unsigned           nn_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_cnt_r <= 5'd16;
      nbr_cnt_r  <= 3'd4;
      for (int i = 0; i < NUM_COST_REGS; i++) begin
        costs_r.cost[i] <= DEFAULT_COST;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEST_IN_USE) begin
        dest_cnt_r <= cfg_wdata[DEST_CNT_W-1:0];
      end
      if (cfg_index == CFG_NBR_IN_USE) begin
        nbr_cnt_r <= cfg_wdata[NBR_CNT_W-1:0];
      end
      if (cfg_index inside {[CFG_LINK_COST_0:CFG_LINK_COST_3]}) begin
        for (int i = 0; i < NUM_COST_REGS; i++) begin
          if (cfg_index == CFG_LINK_COST_0 + CFG_IDX_W'(i) && i < MAX_NEIGHBORS) begin
            costs_r.cost[i] <= cfg_wdata[COST_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    if (dest_cnt_r == '0) begin
      nd_v = 1;
    end else if (32'(dest_cnt_r) > MAX_DESTINATIONS) begin
      nd_v = MAX_DESTINATIONS;
    end else begin
      nd_v = 32'(dest_cnt_r);
    end
    if (nbr_cnt_r == '0) begin
      nn_v = 1;
    end else if (32'(nbr_cnt_r) > MAX_NEIGHBORS) begin
      nn_v = MAX_NEIGHBORS;
    end else begin
      nn_v = 32'(nbr_cnt_r);
    end
  end

  assign nd_m1  = DW'(nd_v - 1);
  assign nn_m1  = JW'(nn_v - 1);
  assign nn_cnt = (REPORT_W + 1)'(nn_v);
  assign costs  = costs_r;

endmodule

// ===== hw/rtl/dvre_relax_dp.sv =====
// relax datapath: saturating sum, compare and running minimum per destination
`timescale 1ns / 1ps

module dvre_relax_dp #(
  parameter int ESTIMATE_BITS = 16,
  parameter int JW            = 2
) (
  input  logic                         clk,
  input  dvre_pkg::relax_ctl_t         ctl,
  input  logic [JW-1:0]                nbr_sel,
  input  logic [ESTIMATE_BITS-1:0]     nbr_est,
  input  logic [ESTIMATE_BITS-1:0]     own_est,
  input  logic [dvre_pkg::HOP_W-1:0]   own_hop,
  input  dvre_pkg::cost_set_t          costs,
  output logic [ESTIMATE_BITS-1:0]     new_est,
  output logic [dvre_pkg::HOP_W-1:0]   new_hop,
  output logic                         new_chg
);
  import dvre_pkg::*;

  localparam int SW = ((ESTIMATE_BITS > COST_W) ? ESTIMATE_BITS : COST_W) + 1;
  localparam logic [SW-1:0] SUM_CAP = SW'({ESTIMATE_BITS{1'b1}});

  logic [ESTIMATE_BITS-1:0] run_est_r;
  logic [HOP_W-1:0]         run_hop_r;
  logic                     run_chg_r;
  logic [ESTIMATE_BITS-1:0] base_est;
  logic [HOP_W-1:0]         base_hop;
  logic                     base_chg;
  logic [COST_W-1:0]        cost;
  logic [SW-1:0]            sum;
  logic [ESTIMATE_BITS-1:0] sum_sat;

  always_comb begin
    base_est = ctl.first ? own_est : run_est_r;
    base_hop = ctl.first ? own_hop : run_hop_r;
    base_chg = ctl.first ? 1'b0 : run_chg_r;
    cost     = (32'(nbr_sel) < NUM_COST_REGS) ? costs.cost[2'(nbr_sel)] : DEFAULT_COST;
    sum      = SW'(nbr_est) + SW'(cost);
    sum_sat  = (sum > SUM_CAP) ? {ESTIMATE_BITS{1'b1}} : sum[ESTIMATE_BITS-1:0];
    if (sum_sat < base_est) begin
      new_est = sum_sat;
      new_hop = HOP_W'(nbr_sel);
      new_chg = 1'b1;
    end else begin
      new_est = base_est;
      new_hop = base_hop;
      new_chg = base_chg;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      run_est_r <= new_est;
      run_hop_r <= new_hop;
      run_chg_r <= new_chg;
    end
  end

endmodule

// ===== hw/rtl/distance_vector_relax_engine.sv =====
// top level: sequencer, distance and neighbour tables, result register
`timescale 1ns / 1ps

// After reset the block sweeps its tables to unreachable, one entry a cycle, over
// all MAX_NEIGHBORS * MAX_DESTINATIONS entries; in_ready stays low meanwhile, while
// configuration writes are taken at once. Loads and no-change reports are taken
// in the idle state. A relax round holds in_ready low: when the no-change reports
// counted since the last round start match the neighbours in use it gives a single
// converged word; otherwise it walks the neighbour table one read a cycle, then
// reads each distance entry back through the single table port into the result
// register, a read state and a load state per word, the load waiting while the held
// result is not taken. The next word is taken while the last result still waits.
module distance_vector_relax_engine #(
  parameter int MAX_DESTINATIONS = 16,
  parameter int MAX_NEIGHBORS    = 4,
  parameter int ESTIMATE_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dvre_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dvre_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [dvre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dvre_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dvre_pkg::*;

  localparam int DW        = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
  localparam int JW        = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int NBR_DEPTH = MAX_NEIGHBORS * MAX_DESTINATIONS;
  localparam int NAW       = (NBR_DEPTH > 1) ? $clog2(NBR_DEPTH) : 1;
  localparam logic [NAW-1:0] CLR_LAST = NAW'(NBR_DEPTH - 1);
  localparam logic [ESTIMATE_BITS-1:0] EST_ONES = {ESTIMATE_BITS{1'b1}};

  state_t                   state_r, state_nxt;
  logic [NAW-1:0]           clr_cnt_r;
  logic [DW-1:0]            di_r;
  logic [JW-1:0]            ji_r;
  logic [DW-1:0]            ed_r;
  relax_ctl_t               p_ctl_r;
  logic [DW-1:0]            p_d_r;
  logic [JW-1:0]            p_j_r;
  logic [REPORT_W-1:0]      reports_r;
  logic                     round_chg_r;
  logic [MAX_DESTINATIONS-1:0] chg_bits_r;
  logic                     out_valid_r;
  out_word_t                out_word_r;
  out_word_t                out_word_nxt;

  logic [ESTIMATE_BITS-1:0] nbr_mem [NBR_DEPTH];
  logic [ESTIMATE_BITS-1:0] own_est_mem [MAX_DESTINATIONS];
  logic [HOP_W-1:0]         own_hop_mem [MAX_DESTINATIONS];
  logic [ESTIMATE_BITS-1:0] nbr_rd_r;
  logic [ESTIMATE_BITS-1:0] own_est_rd_r;
  logic [HOP_W-1:0]         own_hop_rd_r;

  logic                     nbr_we;
  logic [NAW-1:0]           nbr_waddr;
  logic [ESTIMATE_BITS-1:0] nbr_wdata;
  logic [NAW-1:0]           nbr_raddr;
  logic                     own_we;
  logic [DW-1:0]            own_waddr;
  logic [ESTIMATE_BITS-1:0] own_west;
  logic [HOP_W-1:0]         own_whop;
  logic                     own_re;
  logic [DW-1:0]            own_raddr;
  logic                     out_load;

  logic [DW-1:0]            nd_m1;
  logic [JW-1:0]            nn_m1;
  logic [REPORT_W:0]        nn_cnt;
  cost_set_t                costs;
  logic [ESTIMATE_BITS-1:0] dp_est;
  logic [HOP_W-1:0]         dp_hop;
  logic                     dp_chg;

  logic                     in_fire;
  logic                     slot_free;
  logic                     nb_ok;
  logic                     dst_ok;
  logic [ESTIMATE_BITS-1:0] in_est;
  logic                     is_conv;
  logic                     relax_start;
  logic                     walk_done;
  logic                     dp_wr;

  dvre_cfg #(
    .MAX_DESTINATIONS (MAX_DESTINATIONS),
    .MAX_NEIGHBORS    (MAX_NEIGHBORS),
    .DW               (DW),
    .JW               (JW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .nd_m1     (nd_m1),
    .nn_m1     (nn_m1),
    .nn_cnt    (nn_cnt),
    .costs     (costs)
  );

  dvre_relax_dp #(
    .ESTIMATE_BITS (ESTIMATE_BITS),
    .JW            (JW)
  ) u_relax_dp (
    .clk     (clk),
    .ctl     (p_ctl_r),
    .nbr_sel (p_j_r),
    .nbr_est (nbr_rd_r),
    .own_est (own_est_rd_r),
    .own_hop (own_hop_rd_r),
    .costs   (costs),
    .new_est (dp_est),
    .new_hop (dp_hop),
    .new_chg (dp_chg)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign nb_ok       = 32'(in_data.neighbor_index) < MAX_NEIGHBORS;
  assign dst_ok      = 32'(in_data.destination) < MAX_DESTINATIONS;
  assign in_est      = ESTIMATE_BITS'(in_data.estimate);
  assign is_conv     = ({1'b0, reports_r} == nn_cnt);
  assign relax_start = in_fire && (in_data.operation == OP_RELAX) && !is_conv;
  assign walk_done   = (di_r == nd_m1) && (ji_r == nn_m1);
  assign dp_wr       = p_ctl_r.valid && p_ctl_r.last;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && in_data.operation == OP_RELAX) begin
          state_nxt = is_conv ? ST_CONV : ST_RELAX;
        end
      end
      ST_CONV: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_RELAX: begin
        if (walk_done) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (slot_free) state_nxt = (ed_r == nd_m1) ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // table ports and result word
  always_comb begin
    nbr_we       = 1'b0;
    nbr_waddr    = NAW'(32'(in_data.neighbor_index) * MAX_DESTINATIONS
                        + 32'(in_data.destination));
    nbr_wdata    = in_est;
    nbr_raddr    = NAW'(32'(ji_r) * MAX_DESTINATIONS + 32'(di_r));
    own_we       = 1'b0;
    own_waddr    = DW'(in_data.destination);
    own_west     = in_est;
    own_whop     = NO_HOP;
    own_re       = 1'b0;
    own_raddr    = di_r;
    out_load     = 1'b0;
    out_word_nxt = '0;
    case (state_r)
      ST_CLEAR: begin
        nbr_we    = 1'b1;
        nbr_waddr = clr_cnt_r;
        nbr_wdata = EST_ONES;
        own_we    = 32'(clr_cnt_r) < MAX_DESTINATIONS;
        own_waddr = DW'(clr_cnt_r);
        own_west  = EST_ONES;
      end
      ST_IDLE: begin
        if (in_fire && in_data.operation == OP_LOAD_NBR) nbr_we = nb_ok && dst_ok;
        if (in_fire && in_data.operation == OP_LOAD_OWN) own_we = dst_ok;
      end
      ST_CONV: begin
        out_load               = slot_free;
        out_word_nxt.next_hop  = NO_HOP;
        out_word_nxt.converged = 1'b1;
        out_word_nxt.last      = 1'b1;
      end
      ST_RELAX: begin
        own_re = 1'b1;
      end
      ST_EMIT_RD: begin
        own_re    = 1'b1;
        own_raddr = ed_r;
      end
      ST_EMIT_LD: begin
        out_load                   = slot_free;
        out_word_nxt.dest_index    = DEST_FIELD_W'(ed_r);
        out_word_nxt.best_estimate = EST_FIELD_W'(own_est_rd_r);
        out_word_nxt.next_hop      = own_hop_rd_r;
        out_word_nxt.entry_changed = chg_bits_r[ed_r];
        out_word_nxt.table_changed = round_chg_r;
        out_word_nxt.last          = (ed_r == nd_m1);
      end
      default: begin
      end
    endcase
    if (dp_wr) begin
      own_we    = 1'b1;
      own_waddr = p_d_r;
      own_west  = dp_est;
      own_whop  = dp_hop;
    end
  end

  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
    nbr_rd_r <= nbr_mem[nbr_raddr];
    if (own_we) begin
      own_est_mem[own_waddr] <= own_west;
      own_hop_mem[own_waddr] <= own_whop;
    end
    if (own_re) begin
      own_est_rd_r <= own_est_mem[own_raddr];
      own_hop_rd_r <= own_hop_mem[own_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      di_r        <= '0;
      ji_r        <= '0;
      ed_r        <= '0;
      p_ctl_r     <= '0;
      reports_r   <= '0;
      round_chg_r <= 1'b0;
      chg_bits_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (relax_start) begin
        di_r        <= '0;
        ji_r        <= '0;
        ed_r        <= '0;
        reports_r   <= '0;
        round_chg_r <= 1'b0;
      end else begin
        if (state_r == ST_RELAX) begin
          if (ji_r == nn_m1) begin
            ji_r <= '0;
            di_r <= di_r + 1'b1;
          end else begin
            ji_r <= ji_r + 1'b1;
          end
        end
        if (state_r == ST_EMIT_LD && slot_free) ed_r <= ed_r + 1'b1;
        if (in_fire && in_data.operation == OP_NBR_UNCHANGED && nb_ok
            && reports_r != REPORT_FULL) begin
          reports_r <= reports_r + 1'b1;
        end
        if (dp_wr && dp_chg) round_chg_r <= 1'b1;
      end

      p_ctl_r.valid <= (state_r == ST_RELAX);
      p_ctl_r.first <= (ji_r == '0);
      p_ctl_r.last  <= (ji_r == nn_m1);
      if (dp_wr) chg_bits_r[p_d_r] <= dp_chg;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_d_r <= di_r;
    p_j_r <= ji_r;
    if (out_load) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && out_valid_r && !out_ready))
    else $error("result word overwritten while waiting");

  a_conv_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.converged |-> out_data.last && !out_data.table_changed)
    else $error("converged word without last");

  a_stage_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_ctl_r.valid |-> (state_r == ST_RELAX || state_r == ST_TAIL))
    else $error("relax stage active outside walk");

  a_reports_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELAX && $past(state_r) == ST_IDLE) |-> reports_r == '0)
    else $error("report count not cleared at round start");

endmodule
